### src/irpd_pkg.sv
// Shared types and constants for the infrared pulse-distance frame sender.
package irpd_pkg;

  localparam int TICK_W = 15;
  localparam int CMD_W  = 32;
  localparam int MASK_W = 3;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRE_FIRST  = 3'd0,
    CFG_PRE_SECOND = 3'd1,
    CFG_ZERO_FIRST = 3'd2,
    CFG_ZERO_SECOND = 3'd3,
    CFG_ONE_FIRST  = 3'd4,
    CFG_ONE_SECOND = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [TICK_W-1:0] pre_first;
    logic [TICK_W-1:0] pre_second;
    logic [TICK_W-1:0] zero_first;
    logic [TICK_W-1:0] zero_second;
    logic [TICK_W-1:0] one_first;
    logic [TICK_W-1:0] one_second;
  } cfg_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    logic [MASK_W-1:0] levels;
  } res_t;

endpackage

### src/irpd_cfg.sv
// Half-symbol duration registers written through the configuration channel.
module irpd_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [irpd_pkg::TICK_W-1:0]        wr_data,
  output irpd_pkg::cfg_t                     cfg
);

  irpd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pre_first   <= irpd_pkg::TICK_W'(1);
      cfg_r.pre_second  <= irpd_pkg::TICK_W'(1);
      cfg_r.zero_first  <= irpd_pkg::TICK_W'(1);
      cfg_r.zero_second <= irpd_pkg::TICK_W'(1);
      cfg_r.one_first   <= irpd_pkg::TICK_W'(1);
      cfg_r.one_second  <= irpd_pkg::TICK_W'(1);
    end else if (wr_en) begin
      case (wr_index)
        irpd_pkg::CFG_PRE_FIRST:   cfg_r.pre_first   <= wr_data;
        irpd_pkg::CFG_PRE_SECOND:  cfg_r.pre_second  <= wr_data;
        irpd_pkg::CFG_ZERO_FIRST:  cfg_r.zero_first  <= wr_data;
        irpd_pkg::CFG_ZERO_SECOND: cfg_r.zero_second <= wr_data;
        irpd_pkg::CFG_ONE_FIRST:   cfg_r.one_first   <= wr_data;
        irpd_pkg::CFG_ONE_SECOND:  cfg_r.one_second  <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### src/irpd_seq.sv
// Frame sequencer: symbol position, half-symbol tick counter and level output.
module irpd_seq #(
  parameter int FRAME_BYTES = 4,
  parameter int COPIES      = 3
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             acc,
  input  logic                             op,
  input  logic [irpd_pkg::CMD_W-1:0]       word,
  input  logic [irpd_pkg::MASK_W-1:0]      mask,
  input  irpd_pkg::cfg_t                   cfg,
  output irpd_pkg::res_t                   res
);

  localparam int NBITS  = FRAME_BYTES * 8;
  // The position must be wide enough to compare against the 32 command bits.
  localparam int POS_W  = ($clog2(NBITS + 3) < 6) ? 6 : $clog2(NBITS + 3);
  localparam int COPY_W = (COPIES < 2) ? 1 : $clog2(COPIES + 1);
  localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(NBITS + 2);
  localparam logic [POS_W-1:0]  POS_TRAIL1 = POS_W'(NBITS + 1);
  localparam logic [POS_W-1:0]  POS_NBITS  = POS_W'(NBITS);
  localparam logic [COPY_W-1:0] COPY_LAST  = COPY_W'(COPIES - 1);

  logic                          active_r, active_nxt;
  logic [irpd_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [irpd_pkg::MASK_W-1:0]   sel_r, sel_nxt;
  logic [COPY_W-1:0]             copy_r, copy_nxt;
  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic                          half_r, half_nxt;
  logic                          post_r, post_nxt;
  logic [irpd_pkg::TICK_W-1:0]   ticks_r, ticks_nxt;

  // Data positions 1..NBITS carry the command MSB first; past bit 31 they send zero.
  function automatic logic pos_bit(input logic [POS_W-1:0] pos,
                                   input logic [irpd_pkg::CMD_W-1:0] cmd);
    logic [POS_W-1:0] idx;
    logic             b;
    idx = pos - POS_W'(1);
    if (pos != '0 && pos <= POS_NBITS) begin
      if (idx < POS_W'(irpd_pkg::CMD_W)) b = cmd[~idx[4:0]];
      else b = 1'b0;
    end else begin
      b = (pos == POS_TRAIL1);
    end
    return b;
  endfunction

  function automatic logic [irpd_pkg::TICK_W-1:0] nz(input logic [irpd_pkg::TICK_W-1:0] d);
    return (d == '0) ? irpd_pkg::TICK_W'(1) : d;
  endfunction

  function automatic logic [irpd_pkg::TICK_W-1:0] duration(
      input logic post, input logic [POS_W-1:0] pos, input logic half,
      input logic [irpd_pkg::CMD_W-1:0] cmd, input irpd_pkg::cfg_t c);
    logic [irpd_pkg::TICK_W-1:0] d;
    if (post) d = half ? c.zero_first : c.pre_first;
    else if (pos == '0) d = half ? c.pre_second : c.pre_first;
    else if (pos_bit(pos, cmd)) d = half ? c.one_second : c.one_first;
    else d = half ? c.zero_second : c.zero_first;
    return nz(d);
  endfunction

  logic lvl;

  always_comb begin
    if (post_r) lvl = 1'b1;
    else if (pos_r == '0) lvl = ~half_r;
    else lvl = pos_bit(pos_r, cmd_r) ^ ~half_r;
  end

  always_comb begin
    active_nxt = active_r;
    cmd_nxt    = cmd_r;
    sel_nxt    = sel_r;
    copy_nxt   = copy_r;
    pos_nxt    = pos_r;
    half_nxt   = half_r;
    post_nxt   = post_r;
    ticks_nxt  = ticks_r;
    res.levels = '0;
    res.busy   = 1'b0;
    res.done   = 1'b0;
    if (acc) begin
      if (op == irpd_pkg::OP_START) begin
        res.busy = 1'b1;
        if (!active_r) begin
          cmd_nxt    = word;
          sel_nxt    = mask;
          active_nxt = 1'b1;
          copy_nxt   = '0;
          pos_nxt    = '0;
          half_nxt   = 1'b0;
          post_nxt   = 1'b0;
          ticks_nxt  = nz(cfg.pre_first);
        end else begin
          res.levels = lvl ? sel_r : '0;
        end
      end else if (active_r) begin
        res.levels = lvl ? sel_r : '0;
        res.busy   = 1'b1;
        if (ticks_r > irpd_pkg::TICK_W'(1)) begin
          ticks_nxt = ticks_r - irpd_pkg::TICK_W'(1);
        end else if (!half_r) begin
          half_nxt  = 1'b1;
          ticks_nxt = duration(post_r, pos_r, 1'b1, cmd_r, cfg);
        end else if (post_r) begin
          // End of the postamble closes the whole sequence.
          half_nxt   = 1'b0;
          active_nxt = 1'b0;
          post_nxt   = 1'b0;
          copy_nxt   = '0;
          pos_nxt    = '0;
          ticks_nxt  = '0;
          res.done   = 1'b1;
        end else begin
          half_nxt = 1'b0;
          if (pos_r == POS_LAST) begin
            pos_nxt  = '0;
            copy_nxt = copy_r + COPY_W'(1);
            if (copy_r >= COPY_LAST) post_nxt = 1'b1;
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
          ticks_nxt = duration(post_nxt, pos_nxt, 1'b0, cmd_r, cfg);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      copy_r   <= '0;
      pos_r    <= '0;
      half_r   <= 1'b0;
      post_r   <= 1'b0;
      ticks_r  <= '0;
    end else begin
      active_r <= active_nxt;
      copy_r   <= copy_nxt;
      pos_r    <= pos_nxt;
      half_r   <= half_nxt;
      post_r   <= post_nxt;
      ticks_r  <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= '0;
      sel_r <= '0;
    end else begin
      cmd_r <= cmd_nxt;
      sel_r <= sel_nxt;
    end
  end

endmodule

### src/irpd_out.sv
// Result register: holds one word until the receiver takes it.
module irpd_out (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  irpd_pkg::res_t  din,
  output logic            can_load,
  output logic            out_valid,
  input  logic            out_ready,
  output irpd_pkg::res_t  dout
);

  logic           valid_r, valid_nxt;
  irpd_pkg::res_t data_r;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (out_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= din;
  end

  assign out_valid = valid_r;
  assign dout      = data_r;

endmodule

### src/ir_pulse_distance_frame_sender.sv
// Top level of the infrared pulse-distance frame sender.
//
// Input channel (in_*): in_tuser selects a tick (0) or a frame start (1);
// in_tdata carries the 32-bit command and the 3-bit emitter mask, used on start.
// Every accepted input word produces exactly one result word on out_*, holding
// the emitter levels, a busy flag and a done flag for the end of the postamble.
// A start while a sequence is running is answered but otherwise ignored.
// Configuration (cfg_*): six half-symbol durations in ticks, indexes 0..5,
// always ready; writes to other indexes are dropped. Write only while idle.
// The result of a word is on out_tdata in the cycle after it is accepted.
// Throughput: one word per cycle without a stall; the sequencer state updates
// in the accepting cycle and a single result register separates the two channels.
// When the receiver stalls, the result register holds and in_tready drops only
// while that register is full and not being read.
// Reset (rst_n low, synchronous) idles the sequencer, empties the result
// register and sets every duration register to one tick.
module ir_pulse_distance_frame_sender #(
  parameter int FRAME_BYTES = 4,
  parameter int COPIES      = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] frame_word, [34:32] channel_mask, rest zero
  input  logic        in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [2:0] emitter_levels, [3] busy_res, [4] done_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [irpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irpd_pkg::TICK_W-1:0]    cfg_data
);

  irpd_pkg::cfg_t cfg;
  irpd_pkg::res_t res;
  irpd_pkg::res_t res_q;
  logic           acc;
  logic           can_load;

  assign cfg_ready = 1'b1;
  assign in_tready = can_load;
  assign acc       = in_tvalid && can_load;

  irpd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  irpd_seq #(
    .FRAME_BYTES (FRAME_BYTES),
    .COPIES      (COPIES)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .op    (in_tuser),
    .word  (in_tdata[irpd_pkg::CMD_W-1:0]),
    .mask  (in_tdata[irpd_pkg::CMD_W +: irpd_pkg::MASK_W]),
    .cfg   (cfg),
    .res   (res)
  );

  irpd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (acc),
    .din       (res),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .dout      (res_q)
  );

  assign out_tdata = {3'b000, res_q.done, res_q.busy, res_q.levels};

endmodule
